// ----- hw/rtl/ycc420_pkg.sv -----
// Shared types and constants for the RGB to Y'CbCr 4:2:0 converter.
// Used by ycc420_pos, ycc420_csc and rgb_to_ycbcr420_converter. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ycc420_pkg;

    // Largest frame dimension the position counters cover
    localparam int unsigned MAX_DIM_DEF = 4096;

    // Configuration port
    localparam int CFG_W = 13;
    localparam int IDX_W = 2;

    typedef enum logic [IDX_W-1:0] {
        REG_FRAME_WIDTH    = 2'd0,
        REG_FRAME_HEIGHT   = 2'd1,
        REG_SD_WIDTH_LIMIT = 2'd2
    } t_cfg_idx;

    localparam logic [CFG_W-1:0] FRAME_WIDTH_RST    = 13'd1920;
    localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST   = 13'd1080;
    localparam logic [CFG_W-1:0] SD_WIDTH_LIMIT_RST = 13'd720;

    // Q0.16 coefficients, BT.601
    localparam logic [15:0] C601_YR = 16'd16843;
    localparam logic [15:0] C601_YG = 16'd33030;
    localparam logic [15:0] C601_YB = 16'd6423;
    localparam logic [15:0] C601_UR = 16'd9699;
    localparam logic [15:0] C601_UG = 16'd19071;
    localparam logic [15:0] C601_VG = 16'd24117;
    localparam logic [15:0] C601_VB = 16'd4653;
    // Q0.16 coefficients, BT.709
    localparam logic [15:0] C709_YR = 16'd11993;
    localparam logic [15:0] C709_YG = 16'd40239;
    localparam logic [15:0] C709_YB = 16'd4063;
    localparam logic [15:0] C709_UR = 16'd6619;
    localparam logic [15:0] C709_UG = 16'd22217;
    localparam logic [15:0] C709_VG = 16'd26149;
    localparam logic [15:0] C709_VB = 16'd2621;
    // 0.439, shared by both sets
    localparam logic [15:0] C_UVMAX = 16'd28770;

    // Per-pixel position and mode flags that travel with the pixel
    typedef struct packed {
        logic sd;
        logic cvalid;
        logic lend;
        logic fend;
    } t_side;

endpackage

`default_nettype wire

// ----- hw/rtl/ycc420_pos.sv -----
// Column/row position counters for the converter.
// Flags chroma sites, line and frame ends, and picks the coefficient set. Uses ycc420_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ycc420_pos #(
    parameter int unsigned MAX_DIM = ycc420_pkg::MAX_DIM_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_advance,
    input  wire logic [ycc420_pkg::CFG_W-1:0] i_frame_width,
    input  wire logic [ycc420_pkg::CFG_W-1:0] i_frame_height,
    input  wire logic [ycc420_pkg::CFG_W-1:0] i_sd_width_limit,
    output ycc420_pkg::t_side                 o_side
);
    import ycc420_pkg::*;

    localparam int CW = $clog2(MAX_DIM);
    localparam int DW = (CW + 1 > CFG_W) ? CW + 1 : CFG_W;
    localparam logic [DW-1:0] DIM_MAX = DW'(MAX_DIM);

    logic [CW-1:0] r_col, n_col;
    logic [CW-1:0] r_row, n_row;
    logic [DW-1:0] w_eff, h_eff, fw_ext, fh_ext;
    logic [DW-1:0] col_p1, row_p1;
    logic          row_wrap;

    assign fw_ext = DW'(i_frame_width);
    assign fh_ext = DW'(i_frame_height);

    // zero acts as one, oversize clamps to the counter range
    always_comb begin
        if (fw_ext == '0) begin
            w_eff = DW'(1);
        end else if (fw_ext > DIM_MAX) begin
            w_eff = DIM_MAX;
        end else begin
            w_eff = fw_ext;
        end
        if (fh_ext == '0) begin
            h_eff = DW'(1);
        end else if (fh_ext > DIM_MAX) begin
            h_eff = DIM_MAX;
        end else begin
            h_eff = fh_ext;
        end
    end

    assign col_p1   = DW'(r_col) + DW'(1);
    assign row_p1   = DW'(r_row) + DW'(1);
    assign row_wrap = (row_p1 >= h_eff);

    always_comb begin
        o_side.sd     = (i_frame_width <= i_sd_width_limit);
        o_side.cvalid = ~r_col[0] & ~r_row[0];
        o_side.lend   = (col_p1 >= w_eff);
        o_side.fend   = o_side.lend & row_wrap;
    end

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (i_advance) begin
            if (o_side.lend) begin
                n_col = '0;
                n_row = row_wrap ? '0 : CW'(row_p1);
            end else begin
                n_col = CW'(col_p1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/ycc420_csc.sv -----
// Color space conversion datapath: product register, then sum/clamp into the result register.
// Coefficients come from ycc420_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ycc420_csc (
    input  wire logic       i_clk,
    input  wire logic       i_en_prod,
    input  wire logic       i_en_out,
    input  wire logic       i_sd,
    input  wire logic       i_cvalid,
    input  wire logic [7:0] i_red,
    input  wire logic [7:0] i_green,
    input  wire logic [7:0] i_blue,
    output logic      [7:0] o_luma,
    output logic      [7:0] o_blue_diff,
    output logic      [7:0] o_red_diff
);
    import ycc420_pkg::*;

    localparam logic [26:0] Y_OFS = 27'(16) << 16;
    localparam logic [26:0] C_OFS = 27'(128) << 16;
    localparam logic [7:0]  C_NEUTRAL = 8'd128;

    // product slots: Y r/g/b, Cb r/g/b, Cr r/g/b
    localparam int P_YR = 0, P_YG = 1, P_YB = 2;
    localparam int P_UR = 3, P_UG = 4, P_UB = 5;
    localparam int P_VR = 6, P_VG = 7, P_VB = 8;
    localparam int NP   = 9;

    logic [15:0] k_yr, k_yg, k_yb, k_ur, k_ug, k_vg, k_vb;
    logic [23:0] n_p [NP];
    logic [23:0] r_p [NP];
    logic [26:0] s_y, s_cb, s_cr;
    logic [7:0]  n_luma, n_cb, n_cr;

    // drop the fraction; negative floors to 0, overflow saturates
    function automatic logic [7:0] to_byte(input logic [26:0] acc);
        logic [7:0] res;
        if (acc[26]) begin
            res = 8'd0;
        end else if (|acc[25:24]) begin
            res = 8'd255;
        end else begin
            res = acc[23:16];
        end
        return res;
    endfunction

    always_comb begin
        k_yr = i_sd ? C601_YR : C709_YR;
        k_yg = i_sd ? C601_YG : C709_YG;
        k_yb = i_sd ? C601_YB : C709_YB;
        k_ur = i_sd ? C601_UR : C709_UR;
        k_ug = i_sd ? C601_UG : C709_UG;
        k_vg = i_sd ? C601_VG : C709_VG;
        k_vb = i_sd ? C601_VB : C709_VB;
    end

    always_comb begin
        n_p[P_YR] = {8'd0, k_yr}    * {16'd0, i_red};
        n_p[P_YG] = {8'd0, k_yg}    * {16'd0, i_green};
        n_p[P_YB] = {8'd0, k_yb}    * {16'd0, i_blue};
        n_p[P_UR] = {8'd0, k_ur}    * {16'd0, i_red};
        n_p[P_UG] = {8'd0, k_ug}    * {16'd0, i_green};
        n_p[P_UB] = {8'd0, C_UVMAX} * {16'd0, i_blue};
        n_p[P_VR] = {8'd0, C_UVMAX} * {16'd0, i_red};
        n_p[P_VG] = {8'd0, k_vg}    * {16'd0, i_green};
        n_p[P_VB] = {8'd0, k_vb}    * {16'd0, i_blue};
    end

    always_ff @(posedge i_clk) begin
        if (i_en_prod) begin
            r_p <= n_p;
        end
    end

    always_comb begin
        s_y  = 27'(r_p[P_YR]) + 27'(r_p[P_YG]) + 27'(r_p[P_YB]) + Y_OFS;
        s_cb = 27'(r_p[P_UB]) - 27'(r_p[P_UR]) - 27'(r_p[P_UG]) + C_OFS;
        s_cr = 27'(r_p[P_VR]) - 27'(r_p[P_VG]) - 27'(r_p[P_VB]) + C_OFS;
        n_luma = to_byte(s_y);
        n_cb   = i_cvalid ? to_byte(s_cb) : C_NEUTRAL;
        n_cr   = i_cvalid ? to_byte(s_cr) : C_NEUTRAL;
    end

    always_ff @(posedge i_clk) begin
        if (i_en_out) begin
            o_luma      <= n_luma;
            o_blue_diff <= n_cb;
            o_red_diff  <= n_cr;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/rgb_to_ycbcr420_converter.sv -----
// Top level of the RGB to studio-range Y'CbCr 4:2:0 converter.
// Instantiates ycc420_pos and ycc420_csc; types and constants from ycc420_pkg.
//
//   channel   dir  handshake                   payload
//   pixel in  in   i_in_valid / o_in_stall     i_red, i_green, i_blue
//   result    out  o_out_valid / i_out_stall   o_luma, o_chroma_valid, o_blue_diff,
//                                              o_red_diff, o_line_end, o_frame_end
//   config    in   i_cfg_valid / o_cfg_ready   i_cfg_index, i_cfg_data
//
// One pixel per clock unless the result side stalls; registered in the input, product
// and result registers. Position flags are taken when the pixel is accepted.
// Synchronous active-low reset clears the counters and stage valids, presets config
// registers. A result-side stall backs up stage by stage; empty stages keep filling.
`timescale 1ns / 1ps
`default_nettype none

module rgb_to_ycbcr420_converter #(
    parameter int unsigned MAX_DIM = ycc420_pkg::MAX_DIM_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    // pixel in
    input  wire logic                         i_in_valid,
    output logic                              o_in_stall,
    input  wire logic [7:0]                   i_red,
    input  wire logic [7:0]                   i_green,
    input  wire logic [7:0]                   i_blue,
    // result out
    output logic                              o_out_valid,
    input  wire logic                         i_out_stall,
    output logic      [7:0]                   o_luma,
    output logic                              o_chroma_valid,
    output logic      [7:0]                   o_blue_diff,
    output logic      [7:0]                   o_red_diff,
    output logic                              o_line_end,
    output logic                              o_frame_end,
    // configuration
    input  wire logic                         i_cfg_valid,
    output logic                              o_cfg_ready,
    input  wire logic [ycc420_pkg::IDX_W-1:0] i_cfg_index,
    input  wire logic [ycc420_pkg::CFG_W-1:0] i_cfg_data
);
    import ycc420_pkg::*;

    logic [CFG_W-1:0] r_frame_width, r_frame_height, r_sd_width_limit;
    logic             r_v1, r_v2, r_v3;
    logic             adv1, adv2, adv3, in_acc;
    logic [7:0]       r_red, r_green, r_blue;
    t_side            pos_side, r_side1, r_side2, r_side3;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width    <= FRAME_WIDTH_RST;
            r_frame_height   <= FRAME_HEIGHT_RST;
            r_sd_width_limit <= SD_WIDTH_LIMIT_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (t_cfg_idx'(i_cfg_index))
                REG_FRAME_WIDTH:    r_frame_width    <= i_cfg_data;
                REG_FRAME_HEIGHT:   r_frame_height   <= i_cfg_data;
                REG_SD_WIDTH_LIMIT: r_sd_width_limit <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // a stage may load when it is empty or its contents move on
    assign adv3       = ~r_v3 | ~i_out_stall;
    assign adv2       = ~r_v2 | adv3;
    assign adv1       = ~r_v1 | adv2;
    assign o_in_stall = ~adv1;
    assign in_acc     = i_in_valid & adv1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (adv1) begin
                r_v1 <= i_in_valid;
            end
            if (adv2) begin
                r_v2 <= r_v1;
            end
            if (adv3) begin
                r_v3 <= r_v2;
            end
        end
    end

    ycc420_pos #(
        .MAX_DIM (MAX_DIM)
    ) u_pos (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_advance        (in_acc),
        .i_frame_width    (r_frame_width),
        .i_frame_height   (r_frame_height),
        .i_sd_width_limit (r_sd_width_limit),
        .o_side           (pos_side)
    );

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_red   <= i_red;
            r_green <= i_green;
            r_blue  <= i_blue;
            r_side1 <= pos_side;
        end
        if (adv2 && r_v1) begin
            r_side2 <= r_side1;
        end
        if (adv3 && r_v2) begin
            r_side3 <= r_side2;
        end
    end

    ycc420_csc u_csc (
        .i_clk       (i_clk),
        .i_en_prod   (adv2 & r_v1),
        .i_en_out    (adv3 & r_v2),
        .i_sd        (r_side1.sd),
        .i_cvalid    (r_side2.cvalid),
        .i_red       (r_red),
        .i_green     (r_green),
        .i_blue      (r_blue),
        .o_luma      (o_luma),
        .o_blue_diff (o_blue_diff),
        .o_red_diff  (o_red_diff)
    );

    assign o_out_valid    = r_v3;
    assign o_chroma_valid = r_side3.cvalid;
    assign o_line_end     = r_side3.lend;
    assign o_frame_end    = r_side3.fend;

endmodule

`default_nettype wire

// ----- bench/tb.sv -----
// Testbench for rgb_to_ycbcr420_converter: a table of directed pixels and register writes,
// then random frames, every result checked against a bit-exact RGB to Y'CbCr 4:2:0 predictor
// (typed rows supply their own colours). Depends on ycc420_pkg and the converter RTL.
`timescale 1ns / 1ps

module tb;
    import ycc420_pkg::*;

    localparam int unsigned DIM_CAP = MAX_DIM_DEF;
    localparam logic [IDX_W-1:0] REG_UNUSED = 2'd3;
    localparam int DRAIN_CYCLES = 4;

    // Q0.16 coefficients
    localparam int K601_YR = 16843;
    localparam int K601_YG = 33030;
    localparam int K601_YB = 6423;
    localparam int K601_UR = 9699;
    localparam int K601_UG = 19071;
    localparam int K601_VG = 24117;
    localparam int K601_VB = 4653;
    localparam int K709_YR = 11993;
    localparam int K709_YG = 40239;
    localparam int K709_YB = 4063;
    localparam int K709_UR = 6619;
    localparam int K709_UG = 22217;
    localparam int K709_VG = 26149;
    localparam int K709_VB = 2621;
    localparam int K_UV_MAX = 28770;

    typedef struct packed {
        logic [7:0] luma;
        logic       chroma_valid;
        logic [7:0] blue_diff;
        logic [7:0] red_diff;
        logic       line_end;
        logic       frame_end;
    } t_ycc;

    typedef enum logic {ROW_PIXEL, ROW_REG} t_row_kind;

    typedef struct packed {
        t_row_kind        kind;
        logic [IDX_W-1:0] idx;
        logic [CFG_W-1:0] data;
        logic [7:0]       r;
        logic [7:0]       g;
        logic [7:0]       b;
        logic             typed;
        logic [7:0]       ey;
        logic [7:0]       ecb;
        logic [7:0]       ecr;
    } t_stim_row;

    localparam int DIR_ROWS = 31;
    // typed rows sit at known positions: counters are deterministic in the item count
    localparam t_stim_row DIRECTED [0:DIR_ROWS-1] = '{
        // reset config: 1920 wide, BT.709
        '{ROW_PIXEL, REG_FRAME_WIDTH, 13'd0, 8'h00, 8'h00, 8'h00, 1'b1, 8'd16, 8'd128, 8'd128},
        '{ROW_PIXEL, REG_FRAME_WIDTH, 13'd0, 8'hFF, 8'hFF, 8'hFF, 1'b1, 8'd235, 8'd128, 8'd128},
        '{ROW_PIXEL, REG_FRAME_WIDTH, 13'd0, 8'hFF, 8'hFF, 8'hFF, 1'b1, 8'd235, 8'd127, 8'd128},
        '{ROW_PIXEL, REG_FRAME_WIDTH, 13'd0, 8'hFF, 8'h00, 8'h00, 1'b0, 8'd0, 8'd0, 8'd0},
        '{ROW_PIXEL, REG_FRAME_WIDTH, 13'd0, 8'h00, 8'hFF, 8'h00, 1'b0, 8'd0, 8'd0, 8'd0},
        '{ROW_PIXEL, REG_FRAME_WIDTH, 13'd0, 8'h00, 8'h00, 8'hFF, 1'b0, 8'd0, 8'd0, 8'd0},
        '{ROW_PIXEL, REG_FRAME_WIDTH, 13'd0, 8'hAA, 8'h55, 8'hF0, 1'b0, 8'd0, 8'd0, 8'd0},
        '{ROW_PIXEL, REG_FRAME_WIDTH, 13'd0, 8'h55, 8'hAA, 8'h0F, 1'b0, 8'd0, 8'd0, 8'd0},
        // shrink to 4x3 with the column counter already past the new line end
        '{ROW_REG, REG_FRAME_WIDTH, 13'd4, 8'h00, 8'h00, 8'h00, 1'b0, 8'd0, 8'd0, 8'd0},
        '{ROW_REG, REG_FRAME_HEIGHT, 13'd3, 8'h00, 8'h00, 8'h00, 1'b0, 8'd0, 8'd0, 8'd0},
        '{ROW_REG, REG_SD_WIDTH_LIMIT, 13'd4, 8'h00, 8'h00, 8'h00, 1'b0, 8'd0, 8'd0, 8'd0},
        '{ROW_PIXEL, REG_FRAME_WIDTH, 13'd0, 8'h00, 8'h00, 8'h00, 1'b1, 8'd16, 8'd128, 8'd128},
        '{ROW_PIXEL, REG_FRAME_WIDTH, 13'd0, 8'hFF, 8'hFF, 8'hFF, 1'b1, 8'd235, 8'd128, 8'd128},
        '{ROW_PIXEL, REG_FRAME_WIDTH, 13'd0, 8'hFF, 8'h00, 8'hFF, 1'b0, 8'd0, 8'd0, 8'd0},
        '{ROW_PIXEL, REG_FRAME_WIDTH, 13'd0, 8'h00, 8'hFF, 8'h00, 1'b0, 8'd0, 8'd0, 8'd0},
        '{ROW_PIXEL, REG_FRAME_WIDTH, 13'd0, 8'h80, 8'h7F, 8'h01, 1'b0, 8'd0, 8'd0, 8'd0},
        '{ROW_PIXEL, REG_FRAME_WIDTH, 13'd0, 8'hFF, 8'h00, 8'h00, 1'b1, 8'd81, 8'd90, 8'd239},
        '{ROW_PIXEL, REG_FRAME_WIDTH, 13'd0, 8'h10, 8'h20, 8'h30, 1'b0, 8'd0, 8'd0, 8'd0},
        '{ROW_PIXEL, REG_FRAME_WIDTH, 13'd0, 8'h00, 8'h00, 8'hFF, 1'b1, 8'd40, 8'd239, 8'd109},
        '{ROW_PIXEL, REG_FRAME_WIDTH, 13'd0, 8'hC8, 8'h64, 8'h32, 1'b0, 8'd0, 8'd0, 8'd0},
        // zero size acts as 1x1; a write to the unused index is dropped
        '{ROW_REG, REG_FRAME_WIDTH, 13'd0, 8'h00, 8'h00, 8'h00, 1'b0, 8'd0, 8'd0, 8'd0},
        '{ROW_REG, REG_FRAME_HEIGHT, 13'd0, 8'h00, 8'h00, 8'h00, 1'b0, 8'd0, 8'd0, 8'd0},
        '{ROW_REG, REG_UNUSED, 13'h1FFF, 8'h00, 8'h00, 8'h00, 1'b0, 8'd0, 8'd0, 8'd0},
        '{ROW_PIXEL, REG_FRAME_WIDTH, 13'd0, 8'hFE, 8'h01, 8'h7F, 1'b0, 8'd0, 8'd0, 8'd0},
        '{ROW_PIXEL, REG_FRAME_WIDTH, 13'd0, 8'h01, 8'hFE, 8'h80, 1'b0, 8'd0, 8'd0, 8'd0},
        // oversize clamps to the counter range, coefficient pick sees the raw width
        '{ROW_REG, REG_FRAME_WIDTH, 13'h1FFF, 8'h00, 8'h00, 8'h00, 1'b0, 8'd0, 8'd0, 8'd0},
        '{ROW_REG, REG_FRAME_HEIGHT, 13'h1FFF, 8'h00, 8'h00, 8'h00, 1'b0, 8'd0, 8'd0, 8'd0},
        '{ROW_REG, REG_SD_WIDTH_LIMIT, 13'd0, 8'h00, 8'h00, 8'h00, 1'b0, 8'd0, 8'd0, 8'd0},
        '{ROW_PIXEL, REG_FRAME_WIDTH, 13'd0, 8'hFF, 8'hFF, 8'hFF, 1'b1, 8'd235, 8'd127, 8'd128},
        '{ROW_PIXEL, REG_FRAME_WIDTH, 13'd0, 8'h00, 8'h00, 8'hFF, 1'b0, 8'd0, 8'd0, 8'd0},
        '{ROW_PIXEL, REG_FRAME_WIDTH, 13'd0, 8'h3C, 8'hC3, 8'h99, 1'b0, 8'd0, 8'd0, 8'd0}
    };

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_stall;
    logic [7:0]           i_red = '0;
    logic [7:0]           i_green = '0;
    logic [7:0]           i_blue = '0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    logic [7:0]           o_luma;
    logic                 o_chroma_valid;
    logic [7:0]           o_blue_diff;
    logic [7:0]           o_red_diff;
    logic                 o_line_end;
    logic                 o_frame_end;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [IDX_W-1:0]     i_cfg_index = REG_FRAME_WIDTH;
    logic [CFG_W-1:0]     i_cfg_data = '0;

    // predictor state
    logic [CFG_W-1:0]     width_reg;
    logic [CFG_W-1:0]     height_reg;
    logic [CFG_W-1:0]     limit_reg;
    int                   col_pos;
    int                   row_pos;

    t_ycc                 pending_ycc [$];
    int                   mismatches = 0;

    logic                 hold_req = 1'b0;
    logic                 quiet_out = 1'b0;
    int                   hold_left = 0;
    bit                   hold_taken = 1'b0;

    rgb_to_ycbcr420_converter #(
        .MAX_DIM(DIM_CAP)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_red         (i_red),
        .i_green       (i_green),
        .i_blue        (i_blue),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_luma        (o_luma),
        .o_chroma_valid(o_chroma_valid),
        .o_blue_diff   (o_blue_diff),
        .o_red_diff    (o_red_diff),
        .o_line_end    (o_line_end),
        .o_frame_end   (o_frame_end),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #6 i_clk = ~i_clk;

    // drop the 16 fraction bits, clamp to a byte
    function automatic logic [7:0] sat_byte(int acc);
        int q;
        if (acc < 0) return 8'd0;
        q = acc / 65536;
        if (q > 255) return 8'd255;
        return q[7:0];
    endfunction

    function automatic int unsigned eff_dim(logic [CFG_W-1:0] v);
        if (v == '0) return 1;
        if (v > DIM_CAP) return DIM_CAP;
        return v;
    endfunction

    task automatic rgb_to_ycc(input logic [7:0] r, g, b, output t_ycc res);
        int          ri;
        int          gi;
        int          bi;
        int unsigned w;
        int unsigned h;
        bit          bt601;
        ri = r;
        gi = g;
        bi = b;
        w = eff_dim(width_reg);
        h = eff_dim(height_reg);
        bt601 = width_reg <= limit_reg;
        res.chroma_valid = !col_pos[0] && !row_pos[0];
        res.line_end = (col_pos + 1) >= w;
        res.frame_end = res.line_end && ((row_pos + 1) >= h);
        res.blue_diff = 8'd128;
        res.red_diff = 8'd128;
        if (bt601) begin
            res.luma = sat_byte(K601_YR * ri + K601_YG * gi + K601_YB * bi + (16 << 16));
            if (res.chroma_valid) begin
                res.blue_diff = sat_byte(K_UV_MAX * bi - K601_UR * ri - K601_UG * gi
                                         + (128 << 16));
                res.red_diff = sat_byte(K_UV_MAX * ri - K601_VG * gi - K601_VB * bi
                                        + (128 << 16));
            end
        end else begin
            res.luma = sat_byte(K709_YR * ri + K709_YG * gi + K709_YB * bi + (16 << 16));
            if (res.chroma_valid) begin
                res.blue_diff = sat_byte(K_UV_MAX * bi - K709_UR * ri - K709_UG * gi
                                         + (128 << 16));
                res.red_diff = sat_byte(K_UV_MAX * ri - K709_VG * gi - K709_VB * bi
                                        + (128 << 16));
            end
        end
        if (res.line_end) begin
            col_pos = 0;
            row_pos = ((row_pos + 1) >= h) ? 0 : row_pos + 1;
        end else begin
            col_pos = col_pos + 1;
        end
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            REG_FRAME_WIDTH:    width_reg = val;
            REG_FRAME_HEIGHT:   height_reg = val;
            REG_SD_WIDTH_LIMIT: limit_reg = val;
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    // typed values override the predicted color fields; position flags always predicted
    task automatic drive_pixel(input logic [7:0] r, g, b, input logic typed,
                               input logic [7:0] ey, ecb, ecr, input bit may_idle);
        t_ycc res;
        if (may_idle) begin
            while ($urandom_range(99) < 19) begin
                i_in_valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        i_in_valid <= 1'b1;
        i_red <= r;
        i_green <= g;
        i_blue <= b;
        do @(posedge i_clk); while (o_in_stall);
        rgb_to_ycc(r, g, b, res);
        if (typed) begin
            res.luma = ey;
            res.blue_diff = ecb;
            res.red_diff = ecr;
        end
        pending_ycc.push_back(res);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (pending_ycc.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [7:0] rand_chan();
        case ($urandom_range(7))
            0: return 8'h00;
            1: return 8'hFF;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    // mostly tiny frames so lines and frames wrap often
    function automatic logic [CFG_W-1:0] pick_dim();
        case ($urandom_range(9))
            0: return '0;
            1: return 13'd1;
            2: return 13'd2;
            3: return 13'd4096;
            4: return '1;
            5: return 13'($urandom_range(8191));
            default: return 13'($urandom_range(12, 1));
        endcase
    endfunction

    function automatic logic [CFG_W-1:0] pick_limit(logic [CFG_W-1:0] fw);
        case ($urandom_range(5))
            0: return '0;
            1: return fw;
            2: return fw - 13'd1;
            3: return '1;
            4: return 13'd4096;
            default: return 13'($urandom_range(8191));
        endcase
    endfunction

    // receiver: random stalls, one long counted hold, one stall-free stretch
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            i_out_stall <= 1'b1;
        end else if (hold_req && !hold_taken) begin
            hold_taken = 1'b1;
            hold_left = 59;
            i_out_stall <= 1'b1;
        end else if (quiet_out) begin
            i_out_stall <= 1'b0;
        end else begin
            i_out_stall <= ($urandom_range(99) < 19);
        end
    end

    always @(posedge i_clk) begin
        t_ycc want;
        t_ycc got;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got = '{o_luma, o_chroma_valid, o_blue_diff, o_red_diff, o_line_end, o_frame_end};
            if (pending_ycc.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%t unexpected result Y=%0d cv=%0b Cb=%0d Cr=%0d le=%0b fe=%0b",
                             $realtime, got.luma, got.chroma_valid, got.blue_diff,
                             got.red_diff, got.line_end, got.frame_end);
            end else begin
                want = pending_ycc.pop_front();
                if (got.luma !== want.luma || got.chroma_valid !== want.chroma_valid
                    || got.blue_diff !== want.blue_diff || got.red_diff !== want.red_diff
                    || got.line_end !== want.line_end || got.frame_end !== want.frame_end) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("%t mismatch exp Y=%0d cv=%0b Cb=%0d Cr=%0d le=%0b fe=%0b",
                                 $realtime, want.luma, want.chroma_valid, want.blue_diff,
                                 want.red_diff, want.line_end, want.frame_end);
                        $display("%t          got Y=%0d cv=%0b Cb=%0d Cr=%0d le=%0b fe=%0b",
                                 $realtime, got.luma, got.chroma_valid, got.blue_diff,
                                 got.red_diff, got.line_end, got.frame_end);
                    end
                end
            end
        end
    end

    initial begin
        #2_400_000;
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        int               k;
        int               ph;
        int               n;
        logic [CFG_W-1:0] fw;
        logic [CFG_W-1:0] fh;
        logic [CFG_W-1:0] sl;
        width_reg = FRAME_WIDTH_RST;
        height_reg = FRAME_HEIGHT_RST;
        limit_reg = SD_WIDTH_LIMIT_RST;
        col_pos = 0;
        row_pos = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (k = 0; k < DIR_ROWS; k++) begin
            if (DIRECTED[k].kind == ROW_REG) begin
                drain();
                write_reg(DIRECTED[k].idx, DIRECTED[k].data);
            end else begin
                drive_pixel(DIRECTED[k].r, DIRECTED[k].g, DIRECTED[k].b, DIRECTED[k].typed,
                            DIRECTED[k].ey, DIRECTED[k].ecb, DIRECTED[k].ecr, 1'b1);
            end
        end

        for (ph = 0; ph < 5; ph++) begin
            drain();
            fw = pick_dim();
            fh = pick_dim();
            sl = pick_limit(fw);
            if (ph == 4) begin
                // largest width, limit equal to it: BT.601 at the edge
                fw = CFG_W'(DIM_CAP);
                sl = CFG_W'(DIM_CAP);
            end
            write_reg(REG_FRAME_WIDTH, fw);
            write_reg(REG_FRAME_HEIGHT, fh);
            write_reg(REG_SD_WIDTH_LIMIT, sl);
            if (ph == 2) quiet_out <= 1'b1;
            for (n = 0; n < 110; n++) begin
                if (ph == 1 && n == 30) hold_req <= 1'b1;
                // phase 2 runs back to back on both sides
                drive_pixel(rand_chan(), rand_chan(), rand_chan(), 1'b0, 8'd0, 8'd0, 8'd0,
                            ph != 2);
            end
            quiet_out <= 1'b0;
        end

        drain();
        repeat (8) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
